### hw/rtl/lfbb_pkg.sv
// ---------------------------------------------------------------------------
// lfbb_pkg: shared definitions for the link failure backoff breaker
// Types, codes, reset values and small arithmetic helpers used by the block.
// ---------------------------------------------------------------------------
`default_nettype none

package lfbb_pkg;

	// Field widths.
	localparam int unsigned MODE_W    = 2;
	localparam int unsigned TIME_W    = 32;
	localparam int unsigned STATUS_W  = 8;
	localparam int unsigned JIT_W     = 9;
	localparam int unsigned LIMIT_W   = 4;
	localparam int unsigned BACKOFF_W = 15;
	localparam int unsigned RUN_W     = 5;
	localparam int unsigned CFG_IDX_W = 2;
	localparam int unsigned CFG_DAT_W = 15;

	// Only the low JITTER_BITS bits of the jitter input are used.
	localparam int unsigned JITTER_BITS = 9;
	localparam logic [BACKOFF_W:0] JITTER_MASK = (BACKOFF_W + 1)'((1 << JITTER_BITS) - 1);

	// Request modes.
	localparam logic [MODE_W-1:0] MODE_GATE   = 2'd0;
	localparam logic [MODE_W-1:0] MODE_REPORT = 2'd1;
	localparam logic [MODE_W-1:0] MODE_CLEAR  = 2'd2;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_FAIL_LIMIT  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_INIT_BACKOFF = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_BACKOFF = 2'd2;

	// Reset values of the configuration registers.
	localparam logic [LIMIT_W-1:0]   FAIL_LIMIT_RST   = 4'd3;
	localparam logic [BACKOFF_W-1:0] INIT_BACKOFF_RST = 15'd100;
	localparam logic [BACKOFF_W-1:0] MAX_BACKOFF_RST  = 15'd20000;

	// Saturation limits and the refusal code.
	localparam logic [BACKOFF_W-1:0] BACKOFF_LIMIT = '1;
	localparam logic [RUN_W-1:0]     RUN_LIMIT     = '1;
	localparam logic [STATUS_W-1:0]  REFUSED_CODE  = 8'hFF;
	localparam logic [STATUS_W-1:0]  STATUS_OK     = 8'h00;

	// Reciprocal of three for a 17-bit right shift; exact for 16-bit inputs.
	localparam logic [16:0] RECIP3 = 17'd43691;

	typedef struct packed {
		logic [LIMIT_W-1:0]   fail_limit;
		logic [BACKOFF_W-1:0] initial_backoff_ms;
		logic [BACKOFF_W-1:0] max_backoff_ms;
	} cfg_t;

	typedef struct packed {
		logic [MODE_W-1:0]   mode;
		logic [TIME_W-1:0]   now_ms;
		logic [STATUS_W-1:0] bus_status;
		logic [JIT_W-1:0]    jitter_ms;
	} item_t;

	typedef struct packed {
		logic                permitted;
		logic [STATUS_W-1:0] status_out;
		logic                online;
		logic                stable;
	} result_t;

	// Division by three through multiplication by the reciprocal.
	function automatic logic [BACKOFF_W-1:0] div3(input logic [BACKOFF_W-1:0] x);
		logic [31:0] prod;
		prod = 32'(x) * 32'(RECIP3);
		return BACKOFF_W'(prod >> 17);
	endfunction

endpackage

`default_nettype wire

### hw/rtl/lfbb_cfg.sv
// ---------------------------------------------------------------------------
// lfbb_cfg: configuration registers
// Holds the failure limit and the two backoff settings, written by index.
// ---------------------------------------------------------------------------
`default_nettype none

module lfbb_cfg (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              cfg_we,
	input  wire logic [lfbb_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [lfbb_pkg::CFG_DAT_W-1:0]    cfg_data,
	output lfbb_pkg::cfg_t                         cfg
);

	lfbb_pkg::cfg_t cfg_q;

	// Register writes; an index outside the list is ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.fail_limit         <= lfbb_pkg::FAIL_LIMIT_RST;
			cfg_q.initial_backoff_ms <= lfbb_pkg::INIT_BACKOFF_RST;
			cfg_q.max_backoff_ms     <= lfbb_pkg::MAX_BACKOFF_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				lfbb_pkg::CFG_FAIL_LIMIT: begin
					cfg_q.fail_limit <= cfg_data[lfbb_pkg::LIMIT_W-1:0];
				end
				lfbb_pkg::CFG_INIT_BACKOFF: begin
					cfg_q.initial_backoff_ms <= cfg_data[lfbb_pkg::BACKOFF_W-1:0];
				end
				lfbb_pkg::CFG_MAX_BACKOFF: begin
					cfg_q.max_backoff_ms <= cfg_data[lfbb_pkg::BACKOFF_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

### hw/rtl/lfbb_health.sv
// ---------------------------------------------------------------------------
// lfbb_health: health state and per-request update
// Keeps the offline flag, failure run, backoff and last failure time, and
// works out the next state and the result of one request in a single pass.
// ---------------------------------------------------------------------------
`default_nettype none

module lfbb_health (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              step,
	input  wire lfbb_pkg::item_t   item,
	input  wire lfbb_pkg::cfg_t    cfg,
	output lfbb_pkg::result_t      res
);

	logic                               offline_q;
	logic [lfbb_pkg::RUN_W-1:0]         fail_run_q;
	logic [lfbb_pkg::BACKOFF_W-1:0]     backoff_q;
	logic [lfbb_pkg::TIME_W-1:0]        last_fail_q;

	logic                               offline_d;
	logic [lfbb_pkg::RUN_W-1:0]         fail_run_d;
	logic [lfbb_pkg::BACKOFF_W-1:0]     backoff_d;
	logic [lfbb_pkg::TIME_W-1:0]        last_fail_d;

	logic [lfbb_pkg::BACKOFF_W:0]       grown;
	logic [lfbb_pkg::BACKOFF_W-1:0]     clamped;
	logic [lfbb_pkg::BACKOFF_W:0]       jittered;
	logic [lfbb_pkg::BACKOFF_W-1:0]     backoff_grown;
	logic [lfbb_pkg::RUN_W-1:0]         run_inc;
	logic                               over_limit;
	logic [lfbb_pkg::TIME_W-1:0]        elapsed;
	logic                               permit;
	logic                               failed;

	// Backoff growth while offline: add a third, clamp, add jitter, saturate.
	always_comb begin
		grown = {1'b0, backoff_q} + {1'b0, lfbb_pkg::div3(backoff_q)};
		if (grown > {1'b0, cfg.max_backoff_ms}) begin
			clamped = cfg.max_backoff_ms;
		end else begin
			clamped = grown[lfbb_pkg::BACKOFF_W-1:0];
		end
		jittered = {1'b0, clamped}
			+ ((lfbb_pkg::BACKOFF_W + 1)'(item.jitter_ms) & lfbb_pkg::JITTER_MASK);
		if (jittered > {1'b0, lfbb_pkg::BACKOFF_LIMIT}) begin
			backoff_grown = lfbb_pkg::BACKOFF_LIMIT;
		end else begin
			backoff_grown = jittered[lfbb_pkg::BACKOFF_W-1:0];
		end
	end

	// Run counter saturates; the old count is tested against the limit.
	assign run_inc    = (fail_run_q == lfbb_pkg::RUN_LIMIT) ? fail_run_q
		: fail_run_q + lfbb_pkg::RUN_W'(1);
	assign over_limit = fail_run_q > lfbb_pkg::RUN_W'(cfg.fail_limit);
	assign failed     = item.bus_status != lfbb_pkg::STATUS_OK;

	// Next state for the request.
	always_comb begin
		offline_d   = offline_q;
		fail_run_d  = fail_run_q;
		backoff_d   = backoff_q;
		last_fail_d = last_fail_q;
		case (item.mode)
			lfbb_pkg::MODE_REPORT: begin
				if (failed) begin
					last_fail_d = item.now_ms;
					if (offline_q) begin
						backoff_d = backoff_grown;
					end else begin
						fail_run_d = run_inc;
						if (over_limit) begin
							offline_d = 1'b1;
							backoff_d = cfg.initial_backoff_ms;
						end
					end
				end else if (fail_run_q != '0) begin
					fail_run_d = '0;
					offline_d  = 1'b0;
				end
			end
			lfbb_pkg::MODE_CLEAR: begin
				offline_d  = 1'b0;
				fail_run_d = '0;
			end
			default: begin
			end
		endcase
	end

	// Gate decision on the updated state, with wrapping elapsed time.
	assign elapsed = item.now_ms - last_fail_d;
	assign permit  = !offline_d || (elapsed > lfbb_pkg::TIME_W'(backoff_d));

	// Result fields.
	always_comb begin
		res.permitted = permit;
		res.online    = !offline_d;
		res.stable    = !offline_d && (fail_run_d == '0);
		case (item.mode)
			lfbb_pkg::MODE_REPORT: res.status_out = item.bus_status;
			lfbb_pkg::MODE_CLEAR:  res.status_out = lfbb_pkg::STATUS_OK;
			default:               res.status_out = permit ? lfbb_pkg::STATUS_OK
				: lfbb_pkg::REFUSED_CODE;
		endcase
	end

	// Health state registers, updated once per request.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offline_q   <= 1'b0;
			fail_run_q  <= '0;
			backoff_q   <= lfbb_pkg::INIT_BACKOFF_RST;
			last_fail_q <= '0;
		end else if (step) begin
			offline_q   <= offline_d;
			fail_run_q  <= fail_run_d;
			backoff_q   <= backoff_d;
			last_fail_q <= last_fail_d;
		end
	end

	// An offline target always has a nonzero failure run behind it.
	a_offline_has_run: assert property (@(posedge clk) disable iff (!arst_n)
		offline_q |-> (fail_run_q != '0))
		else $error("offline with empty failure run");

	// A health reset leaves the target online with no failures.
	a_clear_online: assert property (@(posedge clk) disable iff (!arst_n)
		(step && item.mode == lfbb_pkg::MODE_CLEAR) |=> (!offline_q && fail_run_q == '0))
		else $error("health reset did not clear state");

	// A failure report stamps the time of the failure.
	a_fail_stamp: assert property (@(posedge clk) disable iff (!arst_n)
		(step && item.mode == lfbb_pkg::MODE_REPORT && failed)
		|=> (last_fail_q == $past(item.now_ms)))
		else $error("failure time not recorded");

endmodule

`default_nettype wire

### hw/rtl/link_failure_backoff_breaker_core.sv
// ---------------------------------------------------------------------------
// link_failure_backoff_breaker_core: per-target bus health breaker
// Input register, health update and result register around one pass of logic.
// ---------------------------------------------------------------------------
// Use: each request on the input channel (in_valid / in_stall) is a gate
// query, a transfer outcome report or a health reset. Every request yields
// exactly one result on the output channel (out_valid / out_stall) carrying
// permitted, status_out, online and stable.
// Order: a request is accepted into the input register; when it moves on,
// it updates the health state and is written to the result register,
// which offers the result on the output channel.
// Throughput: one request per cycle while out_stall is low; the health
// update is a single pass of logic between the input register and the
// result register.
// Stalls: while out_stall holds a full result register, a request in the
// input register stays there and in_stall is raised; an empty input register
// still takes one more request. Nothing is lost or repeated.
// Reset: the configuration returns to its defaults (limit 3, initial backoff
// 100 ms, maximum 20000 ms), the target is online with no failures, and both
// channel registers are empty. Configuration writes (cfg_we, cfg_index,
// cfg_data) are taken at any edge, to be made while the block is idle.
// ---------------------------------------------------------------------------
`default_nettype none

module link_failure_backoff_breaker_core (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	// Configuration port.
	input  wire logic                              cfg_we,
	input  wire logic [lfbb_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [lfbb_pkg::CFG_DAT_W-1:0]    cfg_data,
	// Request channel.
	input  wire logic                              in_valid,
	output logic                                   in_stall,
	input  wire logic [lfbb_pkg::MODE_W-1:0]       mode,
	input  wire logic [lfbb_pkg::TIME_W-1:0]       now_ms,
	input  wire logic [lfbb_pkg::STATUS_W-1:0]     bus_status,
	input  wire logic [lfbb_pkg::JIT_W-1:0]        jitter_ms,
	// Result channel.
	output logic                                   out_valid,
	input  wire logic                              out_stall,
	output logic                                   permitted,
	output logic [lfbb_pkg::STATUS_W-1:0]          status_out,
	output logic                                   online,
	output logic                                   stable
);

	lfbb_pkg::cfg_t    cfg;
	lfbb_pkg::item_t   item_s1;
	logic              valid_s1;
	lfbb_pkg::result_t res;
	lfbb_pkg::result_t res_q;
	logic              out_valid_q;
	logic              advance;
	logic              in_take;

	lfbb_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// A held request moves on when the result register is free or draining.
	assign advance  = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !advance;
	assign in_take  = in_valid && !in_stall;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			item_s1.mode       <= mode;
			item_s1.now_ms     <= now_ms;
			item_s1.bus_status <= bus_status;
			item_s1.jitter_ms  <= jitter_ms;
		end
	end

	lfbb_health u_health (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.item   (item_s1),
		.cfg    (cfg),
		.res    (res)
	);

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res;
		end
	end

	assign out_valid  = out_valid_q;
	assign permitted  = res_q.permitted;
	assign status_out = res_q.status_out;
	assign online     = res_q.online;
	assign stable     = res_q.stable;

	// A request that moves on always lands in the result register.
	a_advance_fills: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> out_valid_q)
		else $error("advanced request produced no result");

	// A full, stalled result register holds back the input side.
	a_stall_backs_up: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && out_valid_q && out_stall) |-> (in_stall && !advance))
		else $error("request advanced into a stalled result register");

endmodule

`default_nettype wire
